/* design/transform_matrix_accumulator_defines.svh */
// ----------------------------------------------------------------------------
// Transform matrix accumulator assertion macros
// Shared property forms for the checker of the transform matrix accumulator.
// ----------------------------------------------------------------------------
`ifndef TRANSFORM_MATRIX_ACCUMULATOR_DEFINES_SVH
`define TRANSFORM_MATRIX_ACCUMULATOR_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TMACC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transform matrix accumulator check failed");

// The consequent holds in the cycle after the antecedent.
`define TMACC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("transform matrix accumulator check failed");

`endif

/* design/tmacc_pkg.sv */
// ----------------------------------------------------------------------------
// Transform matrix accumulator package
// Command codes, fixed-point constants and the operand matrix generator.
// ----------------------------------------------------------------------------
package tmacc_pkg;

  typedef enum logic [2:0] {
    CMD_IDENTITY  = 3'd0,
    CMD_TRANSLATE = 3'd1,
    CMD_ROTATE_X  = 3'd2,
    CMD_ROTATE_Y  = 3'd3,
    CMD_ROTATE_Z  = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  localparam int DataW  = 32;
  localparam int OperW  = DataW + 1;        // holds the negated sine exactly
  localparam int ProdW  = DataW + OperW;
  localparam int FracW  = 16;
  localparam int ShW    = ProdW - FracW;
  localparam int AccW   = ShW + 2;          // four terms summed

  localparam logic signed [DataW-1:0] Q_ONE   = 32'sd65536;
  localparam logic signed [DataW-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctl_t;

  // Entry (i, c) of the matrix that the current matrix is post-multiplied by.
  function automatic logic signed [OperW-1:0] op_entry(
    input logic [2:0]              cmd,
    input logic [1:0]              i,
    input logic [1:0]              c,
    input logic signed [OperW-1:0] s,
    input logic signed [OperW-1:0] k,
    input logic signed [OperW-1:0] z
  );
    logic signed [OperW-1:0] ns;
    logic signed [OperW-1:0] one;
    logic signed [OperW-1:0] val;
    ns  = -s;
    one = OperW'(Q_ONE);
    val = (i == c) ? one : '0;
    case (cmd)
      CMD_TRANSLATE: begin
        if (i == 2'd3 && c == 2'd0) val = s;
        if (i == 2'd3 && c == 2'd1) val = k;
        if (i == 2'd3 && c == 2'd2) val = z;
      end
      CMD_ROTATE_X: begin
        if (i == 2'd1 && c == 2'd1) val = k;
        if (i == 2'd1 && c == 2'd2) val = s;
        if (i == 2'd2 && c == 2'd1) val = ns;
        if (i == 2'd2 && c == 2'd2) val = k;
      end
      CMD_ROTATE_Y: begin
        if (i == 2'd0 && c == 2'd0) val = k;
        if (i == 2'd0 && c == 2'd2) val = ns;
        if (i == 2'd2 && c == 2'd0) val = s;
        if (i == 2'd2 && c == 2'd2) val = k;
      end
      CMD_ROTATE_Z: begin
        if (i == 2'd0 && c == 2'd0) val = k;
        if (i == 2'd0 && c == 2'd1) val = s;
        if (i == 2'd1 && c == 2'd0) val = ns;
        if (i == 2'd1 && c == 2'd1) val = k;
      end
      default: begin
      end
    endcase
    return val;
  endfunction

endpackage

/* design/tmacc_mac.sv */
// ----------------------------------------------------------------------------
// Transform matrix accumulator multiply-accumulate unit
// One signed multiplier, floor shift, four-term accumulation and saturation.
// ----------------------------------------------------------------------------
module tmacc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  tmacc_pkg::mac_ctl_t                 ctl,
  input  logic signed [tmacc_pkg::DataW-1:0]  mul_a,
  input  logic signed [tmacc_pkg::OperW-1:0]  mul_b,
  output logic                                res_valid,
  output logic signed [tmacc_pkg::DataW-1:0]  result
);

  logic signed [tmacc_pkg::ProdW-1:0] prod;
  logic                               p_valid;
  logic                               p_first;
  logic                               p_last;
  logic signed [tmacc_pkg::AccW-1:0]  acc;
  logic signed [tmacc_pkg::ShW-1:0]   shifted;
  logic signed [tmacc_pkg::AccW-1:0]  acc_next;
  logic signed [tmacc_pkg::DataW-1:0] sat;

  always_ff @(posedge clk) begin
    prod    <= mul_a * mul_b;
    p_first <= ctl.first;
    p_last  <= ctl.last;
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctl.issue;
    end
  end

  // Dropping the low 16 bits of a signed product rounds toward minus infinity.
  assign shifted  = prod[tmacc_pkg::ProdW-1:tmacc_pkg::FracW];
  assign acc_next = (p_first ? '0 : acc) + tmacc_pkg::AccW'(shifted);

  always_comb begin
    if (acc_next > tmacc_pkg::AccW'(tmacc_pkg::SAT_MAX)) begin
      sat = tmacc_pkg::SAT_MAX;
    end else if (acc_next < tmacc_pkg::AccW'(tmacc_pkg::SAT_MIN)) begin
      sat = tmacc_pkg::SAT_MIN;
    end else begin
      sat = acc_next[tmacc_pkg::DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
    end
    result <= sat;
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= p_valid && p_last;
    end
  end

endmodule

/* design/transform_matrix_accumulator.sv */
// ----------------------------------------------------------------------------
// Transform matrix accumulator
// Keeps a 4x4 Q16.16 homogeneous transform and applies commands to it.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) carry a command and three operands. Identity
// loads the identity matrix. Translate and the three rotations post-multiply
// the matrix through one shared multiply-accumulate unit, four products per
// new entry: each row is loaded into the row buffer, its products are issued
// and the unit is drained, and the input is stalled until the last row is
// written back. A read command emits 16 output beats (out_valid/out_stall) in
// row-major order, one per cycle when the receiver takes them, the first in
// the cycle after the command is accepted; last_entry marks the sixteenth.
// While out_stall is high the current beat holds and the input stays stalled.
// Commands six and seven are taken and ignored.
// Reset loads the identity matrix and leaves the block idle.
// ----------------------------------------------------------------------------
module transform_matrix_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic signed [31:0] operand_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         row_index,
  output logic [1:0]         column_index,
  output logic signed [31:0] entry_value,
  output logic               last_entry
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t                               state;
  state_t                               state_next;
  logic [3:0]                           cnt;
  logic [1:0]                           row;
  logic [1:0]                           wcol;
  logic [2:0]                           cmd;
  logic signed [tmacc_pkg::OperW-1:0]   op_s;
  logic signed [tmacc_pkg::OperW-1:0]   op_k;
  logic signed [tmacc_pkg::OperW-1:0]   op_z;
  logic signed [tmacc_pkg::DataW-1:0]   mat [16];
  logic signed [tmacc_pkg::DataW-1:0]   rowbuf [4];
  logic                                 in_acc;
  logic                                 out_acc;
  logic                                 rotate;
  tmacc_pkg::mac_ctl_t                  ctl;
  logic signed [tmacc_pkg::OperW-1:0]   mul_b;
  logic                                 res_valid;
  logic signed [tmacc_pkg::DataW-1:0]   result;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign out_valid    = (state == ST_READ);
  assign row_index    = cnt[3:2];
  assign column_index = cnt[1:0];
  assign entry_value  = mat[0];
  assign last_entry   = (cnt == 4'd15);

  // The matrix is a circular register; loading an entry into the row buffer or
  // reading out an entry turns it by one place, and sixteen turns bring it back into line.
  assign rotate = (state == ST_LOAD) || ((state == ST_READ) && out_acc);

  assign ctl.issue = (state == ST_ISSUE);
  assign ctl.first = (cnt[1:0] == 2'd0);
  assign ctl.last  = (cnt[1:0] == 2'd3);
  assign mul_b     = tmacc_pkg::op_entry(cmd, cnt[1:0], cnt[3:2], op_s, op_k, op_z);

  tmacc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .mul_a     (rowbuf[cnt[1:0]]),
    .mul_b     (mul_b),
    .res_valid (res_valid),
    .result    (result)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (command)
            tmacc_pkg::CMD_TRANSLATE, tmacc_pkg::CMD_ROTATE_X,
            tmacc_pkg::CMD_ROTATE_Y, tmacc_pkg::CMD_ROTATE_Z: state_next = ST_LOAD;
            tmacc_pkg::CMD_READ: state_next = ST_READ;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (cnt[1:0] == 2'd3) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (cnt == 4'd15) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (res_valid) state_next = (row == 2'd3) ? ST_IDLE : ST_LOAD;
      end
      ST_READ: begin
        if (out_acc && last_entry) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      row   <= '0;
      wcol  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          row <= '0;
        end
        ST_LOAD: begin
          cnt <= (cnt[1:0] == 2'd3) ? 4'd0 : cnt + 4'd1;
        end
        ST_ISSUE: begin
          cnt <= cnt + 4'd1;
        end
        ST_DRAIN: begin
          cnt <= '0;
          if (res_valid) row <= row + 2'd1;
        end
        ST_READ: begin
          if (out_acc) cnt <= cnt + 4'd1;
        end
        default: cnt <= '0;
      endcase
      if (res_valid) wcol <= wcol + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd  <= command;
      op_s <= tmacc_pkg::OperW'(operand_a);
      op_k <= tmacc_pkg::OperW'(operand_b);
      op_z <= tmacc_pkg::OperW'(operand_c);
    end
    if (state == ST_LOAD) begin
      rowbuf[0] <= rowbuf[1];
      rowbuf[1] <= rowbuf[2];
      rowbuf[2] <= rowbuf[3];
      rowbuf[3] <= mat[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_acc && command == tmacc_pkg::CMD_IDENTITY)) begin
      for (int j = 0; j < 16; j++) begin
        mat[j] <= (j % 5 == 0) ? tmacc_pkg::Q_ONE : '0;
      end
    end else if (rotate) begin
      for (int j = 0; j < 15; j++) begin
        mat[j] <= mat[j+1];
      end
      mat[15] <= mat[0];
    end else if (res_valid) begin
      // The row being rebuilt sits in the last four places after its load.
      mat[{2'b11, wcol}] <= result;
    end
  end

endmodule

/* design/tmacc_checker.sv */
// ----------------------------------------------------------------------------
// Transform matrix accumulator checker
// Port-level checks on the read-out beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "transform_matrix_accumulator_defines.svh"

module tmacc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         command,
  input logic signed [31:0] operand_a,
  input logic signed [31:0] operand_b,
  input logic signed [31:0] operand_c,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         row_index,
  input logic [1:0]         column_index,
  input logic signed [31:0] entry_value,
  input logic               last_entry
);

  logic unused_ops;
  assign unused_ops = ^{operand_a, operand_b, operand_c};

  // A stalled beat keeps its payload.
  `TMACC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(entry_value) && $stable(row_index) && $stable(column_index))
  // A read command starts the read-out in the next cycle.
  `TMACC_ASSERT_NEXT(a_read_start, clk, rst, in_valid && !in_stall && command == tmacc_pkg::CMD_READ, out_valid && row_index == 2'd0 && column_index == 2'd0)
  // The read-out ends right after the marked beat is taken.
  `TMACC_ASSERT_NEXT(a_read_end, clk, rst, out_valid && !out_stall && last_entry, !out_valid)
  // No input is taken during a read-out, and the mark sits on the corner.
  `TMACC_ASSERT_SAME(a_read_busy, clk, rst, out_valid, in_stall && (last_entry == (row_index == 2'd3 && column_index == 2'd3)) && !unused_ops == !unused_ops)

endmodule

bind transform_matrix_accumulator tmacc_checker u_tmacc_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Transform matrix accumulator testbench
// Sends identity, translate, rotate, read and unused commands with random gaps and
// output stalls. A local copy of the Q16.16 transform predicts every read-out,
// and each entry beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tmacc_pkg::*;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int RandomCommands = 351;
  localparam int IdleLimit = 4000;
  localparam int MaxReports = 30;
  localparam logic signed [31:0] MaxV = 32'sh7fffffff;
  localparam logic signed [31:0] MinV = 32'sh80000000;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    logic [2:0]         code;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    bit                 drain;
  } cmd_item_t;

  typedef struct {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;
  } entry_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         command = CMD_IDENTITY;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic signed [31:0] operand_c = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         row_index;
  logic [1:0]         column_index;
  logic signed [31:0] entry_value;
  logic               last_entry;

  cmd_item_t          pending_commands[$];
  entry_beat_t        expected_entries[$];
  logic signed [31:0] xform [16];
  int unsigned        cmd_counts [8];
  int unsigned        entries_checked = 0;
  int unsigned        error_count = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        send_gap = 0;
  int unsigned        stall_left = 0;
  bit                 quiet = 1'b0;

  transform_matrix_accumulator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .operand_c    (operand_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_index    (row_index),
    .column_index (column_index),
    .entry_value  (entry_value),
    .last_entry   (last_entry)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    end
  endtask

  // Mostly short gaps, a few long ones, none at all while quiet is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void load_identity();
    for (int n = 0; n < 16; n++) xform[n] = (n % 5 == 0) ? Q_ONE : '0;
  endfunction

  // Applies one accepted command to the local transform and queues the
  // entries that a read-out must produce.
  task automatic update_transform(input cmd_item_t it);
    wide_t              op [16];
    wide_t              s;
    wide_t              k;
    wide_t              sum;
    wide_t              prod;
    logic signed [31:0] nxt [16];
    entry_beat_t        e;
    bit                 mul;
    s   = wide_t'(it.a);
    k   = wide_t'(it.b);
    mul = 1'b1;
    cmd_counts[it.code]++;
    for (int n = 0; n < 16; n++) op[n] = (n % 5 == 0) ? wide_t'(Q_ONE) : '0;
    case (it.code)
      CMD_IDENTITY: begin
        load_identity();
        mul = 1'b0;
      end
      CMD_TRANSLATE: begin
        op[12] = s;
        op[13] = k;
        op[14] = wide_t'(it.c);
      end
      CMD_ROTATE_X: begin
        op[5]  = k;
        op[6]  = s;
        op[9]  = -s;
        op[10] = k;
      end
      CMD_ROTATE_Y: begin
        op[0]  = k;
        op[2]  = -s;
        op[8]  = s;
        op[10] = k;
      end
      CMD_ROTATE_Z: begin
        op[0] = k;
        op[1] = s;
        op[4] = -s;
        op[5] = k;
      end
      CMD_READ: begin
        mul = 1'b0;
        for (int n = 0; n < 16; n++) begin
          e.row   = 2'(n / 4);
          e.col   = 2'(n % 4);
          e.value = xform[n];
          e.last  = (n == 15);
          expected_entries.push_back(e);
        end
      end
      default: begin
        mul = 1'b0;
      end
    endcase
    if (mul) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          sum = '0;
          for (int i = 0; i < 4; i++) begin
            prod = wide_t'(xform[r*4+i]) * op[i*4+c];
            sum  = sum + (prod >>> 16);
          end
          if (sum > wide_t'(SAT_MAX)) nxt[r*4+c] = SAT_MAX;
          else if (sum < wide_t'(SAT_MIN)) nxt[r*4+c] = SAT_MIN;
          else nxt[r*4+c] = sum[31:0];
        end
      end
      for (int n = 0; n < 16; n++) xform[n] = nxt[n];
    end
  endtask

  task automatic add_command(input logic [2:0] code, input logic signed [31:0] a,
                             input logic signed [31:0] b, input logic signed [31:0] c,
                             input bit drain);
    cmd_item_t it;
    it.code  = code;
    it.a     = a;
    it.b     = b;
    it.c     = c;
    it.drain = drain;
    pending_commands.push_back(it);
  endtask

  function automatic logic signed [31:0] shift_amount();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  // Input side: a new beat is presented only once the previous one has gone.
  always @(posedge clk) begin : drive_commands
    cmd_item_t taken;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        taken.code = command;
        taken.a    = operand_a;
        taken.b    = operand_b;
        taken.c    = operand_c;
        update_transform(taken);
      end
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_commands.size() > 0 &&
                   (!pending_commands[0].drain || expected_entries.size() == 0)) begin
        taken     = pending_commands.pop_front();
        command   <= taken.code;
        operand_a <= taken.a;
        operand_b <= taken.b;
        operand_c <= taken.c;
        in_valid  <= 1'b1;
        send_gap  <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) quiet <= !quiet;
  end

  always @(posedge clk) begin : drive_out_stall
    int unsigned n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap();
      out_stall  <= (n > 0);
      stall_left <= (n > 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin : check_entries
    entry_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected entry beat", entry_value, '0);
      end else begin
        want = expected_entries.pop_front();
        entries_checked++;
        if (row_index !== want.row) report_mismatch("row_index", row_index, want.row);
        if (column_index !== want.col)
          report_mismatch("column_index", column_index, want.col);
        if (entry_value !== want.value)
          report_mismatch("entry_value", entry_value, want.value);
        if (last_entry !== want.last) report_mismatch("last_entry", last_entry, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles at %0t", IdleLimit, $time);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned         sent;
    int unsigned         r;
    bit                  drain;
    real                 ang;
    real                 scale;
    logic [2:0]          axis;
    load_identity();
    for (int n = 0; n < 8; n++) cmd_counts[n] = 0;

    // Directed part: reset value, saturation both ways, the negated most
    // negative sine, unused codes, quarter turn and negative rounding.
    add_command(CMD_READ, '0, '0, '0, 1'b0);
    add_command(CMD_TRANSLATE, MaxV, MinV, 32'sd1, 1'b0);
    add_command(CMD_TRANSLATE, MaxV, MinV, -32'sd1, 1'b0);
    add_command(CMD_READ, '0, '0, '0, 1'b0);
    add_command(CMD_ROTATE_X, MinV, MaxV, MaxV, 1'b0);
    add_command(CMD_ROTATE_Y, MaxV, MinV, MinV, 1'b0);
    add_command(CMD_ROTATE_Z, MinV, MinV, '0, 1'b0);
    add_command(CMD_READ, '0, '0, '0, 1'b0);
    add_command(CMD_UNUSED_6, MaxV, MinV, MaxV, 1'b0);
    add_command(CMD_UNUSED_7, MinV, MaxV, MinV, 1'b0);
    add_command(CMD_READ, '0, '0, '0, 1'b0);
    add_command(CMD_IDENTITY, MaxV, MaxV, MaxV, 1'b0);
    add_command(CMD_ROTATE_Z, Q_ONE, '0, MaxV, 1'b0);
    add_command(CMD_TRANSLATE, -32'sd3, 32'sd5, -32'sd7, 1'b0);
    add_command(CMD_ROTATE_X, -32'sd1, 32'sd46341, MinV, 1'b0);
    add_command(CMD_ROTATE_Y, 32'sd46341, -32'sd46341, '0, 1'b0);
    add_command(CMD_READ, '0, '0, '0, 1'b0);
    add_command(CMD_IDENTITY, '0, '0, '0, 1'b0);
    add_command(CMD_READ, MinV, MaxV, -32'sd1, 1'b0);

    // Random part: mostly plausible transforms with frequent reads, plus
    // full-range noise and ignored codes.
    sent = 0;
    while (sent < RandomCommands) begin
      r     = $urandom_range(0, 99);
      drain = (sent == 0) || ($urandom_range(0, 49) == 0);
      sent++;
      if (r < 8) begin
        add_command(CMD_IDENTITY, $urandom, $urandom, $urandom, drain);
      end else if (r < 28) begin
        add_command(CMD_TRANSLATE, shift_amount(), shift_amount(), shift_amount(), drain);
      end else if (r < 55) begin
        ang   = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        scale = ($urandom_range(0, 4) == 0) ? 65536.0 * $urandom_range(1, 40) : 65536.0;
        axis  = 3'(CMD_ROTATE_X + $urandom_range(0, 2));
        add_command(axis, 32'($rtoi($sin(ang) * scale)), 32'($rtoi($cos(ang) * scale)),
                    $urandom, drain);
      end else if (r < 80) begin
        add_command(CMD_READ, $urandom, $urandom, $urandom, drain);
      end else if (r < 86) begin
        add_command($urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7,
                    $urandom, $urandom, $urandom, drain);
      end else begin
        add_command(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, drain);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_commands.size() > 0 || in_valid) @(posedge clk);
    while (expected_entries.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (expected_entries.size() > 0) begin
      report_mismatch("entries never delivered", expected_entries.size(), '0);
    end

    $display("sent %0d identity, %0d translate, %0d rotate, %0d read and %0d unused commands",
             cmd_counts[CMD_IDENTITY], cmd_counts[CMD_TRANSLATE],
             cmd_counts[CMD_ROTATE_X] + cmd_counts[CMD_ROTATE_Y] + cmd_counts[CMD_ROTATE_Z],
             cmd_counts[CMD_READ], cmd_counts[CMD_UNUSED_6] + cmd_counts[CMD_UNUSED_7]);
    $display("checked %0d matrix entry beats, %0d mismatches", entries_checked, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
